FILE: hw/rtl/srn_pkg.sv
// ----------------------------------------------------------------------------
// srn_pkg: shared types and constants of the sparse recurrent network step
// Widths, codes and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package srn_pkg;

  localparam int MaxNeurons = 64;
  localparam int NeuronAw   = $clog2(MaxNeurons);
  localparam int MaxConns   = 256;
  localparam int ConnAw     = $clog2(MaxConns);
  localparam int ValueW     = 16;
  localparam int AccW       = 40;
  localparam int SigW       = 13;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_INPUT = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_INPUTS  = 2'd0,
    CFG_OUTPUTS = 2'd1,
    CFG_HIDDEN  = 2'd2,
    CFG_SPARE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_SIG,
    ST_COMMIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                load;
    logic                acc_clr;
    logic                issue;
    logic [ConnAw-1:0]   conn_idx;
    logic [NeuronAw-1:0] dst;
    logic                sig_start;
    logic                cmt_rd;
  } cmd_t;

  typedef struct packed {
    logic [ConnAw:0]   conn_cnt;
    logic [NeuronAw:0] n;
    logic [NeuronAw:0] base;
    logic              pipe_busy;
    logic              sig_done;
  } sts_t;

endpackage

FILE: hw/rtl/sparse_recurrent_net_step.sv
// ----------------------------------------------------------------------------
// sparse_recurrent_net_step: sparse recurrent network evaluator
// Clear, add-connection and input words are taken in ST_IDLE without raising
// busy. A word with last set, if any neuron is computed, holds busy while each
// computed neuron walks the connection table, drains the pipeline and runs the
// sigmoid, then a sweep strobes one word per cycle; the receiver cannot stall.
// Asynchronous reset empties the table and sets every neuron to 1.0.
// ----------------------------------------------------------------------------
module sparse_recurrent_net_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_data_i,
  input  logic [1:0]         action_i,
  input  logic [5:0]         src_index_i,
  input  logic [5:0]         dst_index_i,
  input  logic signed [15:0] weight_i,
  input  logic [4:0]         input_index_i,
  input  logic signed [15:0] input_value_i,
  input  logic               last_input_i,
  output logic               out_valid_o,
  output logic [4:0]         output_index_o,
  output logic [12:0]        output_value_o,
  output logic               output_on_o,
  output logic               last_o
);
  import srn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srn_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .action_i     (action_i),
    .last_input_i (last_input_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy)
  );

  srn_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .src_index_i    (src_index_i),
    .dst_index_i    (dst_index_i),
    .weight_i       (weight_i),
    .input_index_i  (input_index_i),
    .input_value_i  (input_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .output_index_o (output_index_o),
    .output_value_o (output_value_o),
    .output_on_o    (output_on_o),
    .last_o         (last_o)
  );

endmodule

FILE: hw/rtl/srn_sigmoid.sv
// ----------------------------------------------------------------------------
// srn_sigmoid: iterative fixed-point sigmoid
// Saturates the Q16.24 sum to Q4.12, forms the exponential by one table
// multiply per bit, then divides bit by bit.
// ----------------------------------------------------------------------------
module srn_sigmoid (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [srn_pkg::AccW-1:0]   acc_i,
  output logic                       done_o,
  output logic [srn_pkg::SigW-1:0]   value_o
);
  import srn_pkg::*;

  localparam int ExpSteps = 16;
  localparam int DivSteps = 29;

  function automatic logic [15:0] exp_rom(input logic [3:0] k);
    logic [15:0] r;
    case (k)
      4'd0:    r = 16'd65520;
      4'd1:    r = 16'd65504;
      4'd2:    r = 16'd65472;
      4'd3:    r = 16'd65408;
      4'd4:    r = 16'd65280;
      4'd5:    r = 16'd65026;
      4'd6:    r = 16'd64520;
      4'd7:    r = 16'd63520;
      4'd8:    r = 16'd61565;
      4'd9:    r = 16'd57835;
      4'd10:   r = 16'd51039;
      4'd11:   r = 16'd39750;
      4'd12:   r = 16'd24109;
      4'd13:   r = 16'd8869;
      4'd14:   r = 16'd1200;
      4'd15:   r = 16'd22;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  logic signed [AccW-13:0] q_s;
  logic signed [ValueW-1:0] sat_s;
  logic [ValueW-1:0] abs_s;
  logic [32:0] prod;
  logic [17:0] r2;

  logic busy_q, div_q, neg_q, done_q;
  logic [4:0] k_q;
  logic [ValueW-1:0] a_q;
  logic [16:0] e_q;
  logic [17:0] den_q, rem_q;
  logic [28:0] num_q;

  always_comb begin
    q_s = acc_i[AccW-1:12];
    if (q_s > $signed({{(AccW-12-ValueW){1'b0}}, 1'b0, {(ValueW-1){1'b1}}})) begin
      sat_s = {1'b0, {(ValueW-1){1'b1}}};
    end else if (q_s < $signed({{(AccW-12-ValueW){1'b1}}, 1'b1, {(ValueW-1){1'b0}}})) begin
      sat_s = {1'b1, {(ValueW-1){1'b0}}};
    end else begin
      sat_s = q_s[ValueW-1:0];
    end
    abs_s = sat_s[ValueW-1] ? (~sat_s + 1'b1) : sat_s;
    prod  = e_q * exp_rom(k_q[3:0]) + 33'd32768;
    r2    = {rem_q[16:0], num_q[28]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        div_q  <= 1'b0;
        k_q    <= '0;
      end else if (busy_q && !div_q) begin
        if (k_q == 5'(ExpSteps - 1)) begin
          div_q <= 1'b1;
          k_q   <= '0;
        end else begin
          k_q <= k_q + 5'd1;
        end
      end else if (busy_q) begin
        if (k_q == 5'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= abs_s;
      neg_q <= sat_s[ValueW-1];
      e_q   <= 17'd65536;
    end else if (busy_q && !div_q) begin
      if (a_q[k_q[3:0]]) begin
        e_q <= prod[32:16];
      end
      if (k_q == 5'(ExpSteps - 1)) begin
        den_q <= 18'd65536 + 18'(a_q[k_q[3:0]] ? prod[32:16] : e_q);
        num_q <= 29'(29'd268435456 +
                 29'((18'd65536 + 18'(a_q[k_q[3:0]] ? prod[32:16] : e_q)) >> 1));
        rem_q <= '0;
      end
    end else if (busy_q) begin
      if (r2 >= den_q) begin
        rem_q <= r2 - den_q;
        num_q <= {num_q[27:0], 1'b1};
      end else begin
        rem_q <= r2;
        num_q <= {num_q[27:0], 1'b0};
      end
    end
  end

  assign done_o  = done_q;
  assign value_o = neg_q ? (SigW'(4096) - num_q[SigW-1:0]) : num_q[SigW-1:0];

endmodule

FILE: hw/rtl/srn_datapath.sv
// ----------------------------------------------------------------------------
// srn_datapath: storage and arithmetic of the network step
// Holds the configuration, connection table, neuron values and the
// multiply-accumulate pipeline, and drives the result ports.
// ----------------------------------------------------------------------------
module srn_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [5:0]                     cfg_data_i,
  input  logic [1:0]                     action_i,
  input  logic [5:0]                     src_index_i,
  input  logic [5:0]                     dst_index_i,
  input  logic signed [15:0]             weight_i,
  input  logic [4:0]                     input_index_i,
  input  logic signed [15:0]             input_value_i,
  input  srn_pkg::cmd_t                  cmd_i,
  output srn_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  output logic [4:0]                     output_index_o,
  output logic [12:0]                    output_value_o,
  output logic                           output_on_o,
  output logic                           last_o
);
  import srn_pkg::*;

  typedef struct packed {
    logic [NeuronAw-1:0] src;
    logic [NeuronAw-1:0] dst;
    logic [ValueW-1:0]   w;
  } conn_t;

  logic [4:0] ic_q;
  logic [5:0] oc_q, hc_q;
  logic [ConnAw:0] cnt_q;

  conn_t               conn_mem [MaxConns];
  logic [ValueW-1:0]   nmem [MaxNeurons];
  logic [SigW-1:0]     next_mem [MaxNeurons];
  logic [MaxNeurons-1:0] nvalid_q;

  logic [7:0] sum;
  logic [NeuronAw:0] n, base, avail, rel;
  logic [5:0] outs;

  conn_t conn_q;
  logic v1_q, v2_q, v3_q, hit2_q;
  logic [ValueW-1:0] nrd_q, w2_q;
  logic nvld_q;
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [ValueW-1:0] nval;

  logic sig_done;
  logic [SigW-1:0] sig_val;

  logic cmt_v_q;
  logic [NeuronAw-1:0] cmt_a_q;
  logic [SigW-1:0] nxt_q;

  logic in_we;
  logic [NeuronAw:0] in_addr;

  always_comb begin
    sum   = 8'd1 + 8'(ic_q) + 8'(oc_q) + 8'(hc_q);
    n     = (sum > 8'(MaxNeurons)) ? (NeuronAw+1)'(MaxNeurons) : sum[NeuronAw:0];
    base  = (NeuronAw+1)'(ic_q) + 1'b1;
    avail = (n > base) ? (n - base) : '0;
    outs  = 6'(avail);
    if ({1'b0, outs} > (NeuronAw+1)'(oc_q)) outs = oc_q;
    if (outs > 6'd32) outs = 6'd32;
    in_addr = (NeuronAw+1)'(input_index_i) + 1'b1;
    in_we   = cmd_i.load && (action_i == ACT_INPUT) && (input_index_i < ic_q) &&
              (in_addr < n);
    nval    = nvld_q ? nrd_q : 16'sd4096;
    rel     = {1'b0, cmt_a_q} - base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q     <= 5'd1;
      oc_q     <= 6'd1;
      hc_q     <= 6'd0;
      cnt_q    <= '0;
      nvalid_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      hit2_q   <= 1'b0;
      cmt_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INPUTS:  ic_q <= cfg_data_i[4:0];
          CFG_OUTPUTS: oc_q <= cfg_data_i;
          CFG_HIDDEN:  hc_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (cmd_i.load && action_i == ACT_CLEAR) begin
        cnt_q    <= '0;
        nvalid_q <= '0;
      end
      if (cmd_i.load && action_i == ACT_ADD && cnt_q < (ConnAw+1)'(MaxConns)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (in_we) nvalid_q[in_addr[NeuronAw-1:0]] <= 1'b1;
      if (cmt_v_q) nvalid_q[cmt_a_q] <= 1'b1;
      v1_q    <= cmd_i.issue;
      v2_q    <= v1_q;
      hit2_q  <= v1_q && (conn_q.dst == cmd_i.dst) && ({1'b0, conn_q.src} < n);
      v3_q    <= hit2_q;
      cmt_v_q <= cmd_i.cmt_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && action_i == ACT_ADD && cnt_q < (ConnAw+1)'(MaxConns)) begin
      conn_mem[cnt_q[ConnAw-1:0]] <= '{src: src_index_i, dst: dst_index_i, w: weight_i};
    end
    conn_q <= conn_mem[cmd_i.conn_idx];
  end

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      nmem[in_addr[NeuronAw-1:0]] <= input_value_i;
    end else if (cmt_v_q) begin
      nmem[cmt_a_q] <= ValueW'(nxt_q);
    end
    nrd_q  <= nmem[conn_q.src];
    nvld_q <= nvalid_q[conn_q.src];
    w2_q   <= conn_q.w;
    prod_q <= nval * $signed(w2_q);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sig_done) next_mem[cmd_i.dst] <= sig_val;
    nxt_q   <= next_mem[cmd_i.dst];
    cmt_a_q <= cmd_i.dst;
  end

  srn_sigmoid u_sigmoid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sig_start),
    .acc_i   (acc_q),
    .done_o  (sig_done),
    .value_o (sig_val)
  );

  assign sts_o.conn_cnt  = cnt_q;
  assign sts_o.n         = n;
  assign sts_o.base      = base;
  assign sts_o.pipe_busy = v1_q | v2_q | v3_q;
  assign sts_o.sig_done  = sig_done;

  assign out_valid_o    = cmt_v_q && (rel < (NeuronAw+1)'(outs));
  assign output_index_o = rel[4:0];
  assign output_value_o = nxt_q;
  assign output_on_o    = nxt_q > SigW'(2048);
  assign last_o         = rel == ((NeuronAw+1)'(outs) - 1'b1);

endmodule

FILE: hw/rtl/srn_ctrl.sv
// ----------------------------------------------------------------------------
// srn_ctrl: sequencer of the network step
// Takes words, then walks the connection table once per computed neuron,
// runs the sigmoid and sweeps the new values into the neuron store.
// ----------------------------------------------------------------------------
module srn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     action_i,
  input  logic           last_input_i,
  input  srn_pkg::sts_t  sts_i,
  output srn_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import srn_pkg::*;

  state_e state_q, state_d;
  logic [NeuronAw:0] dst_q, dst_d;
  logic [ConnAw:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dst_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      dst_q   <= dst_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    dst_d         = dst_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.dst     = dst_q[NeuronAw-1:0];
    cmd_o.conn_idx = idx_q[ConnAw-1:0];
    busy_o        = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (action_i == ACT_INPUT && last_input_i && sts_i.base < sts_i.n) begin
            dst_d         = sts_i.base;
            idx_d         = '0;
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (idx_q < sts_i.conn_cnt) begin
          cmd_o.issue = 1'b1;
          idx_d       = idx_q + 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.sig_start = 1'b1;
          state_d         = ST_SIG;
        end
      end
      ST_SIG: begin
        if (sts_i.sig_done) begin
          if (dst_q + 1'b1 < sts_i.n) begin
            dst_d         = dst_q + 1'b1;
            idx_d         = '0;
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_WALK;
          end else begin
            dst_d   = sts_i.base;
            state_d = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        cmd_o.cmt_rd = 1'b1;
        if (dst_q + 1'b1 < sts_i.n) begin
          dst_d = dst_q + 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the sparse recurrent network step
// Drives clear, add-connection and input words through the start/busy
// handshake, mirrors the network in a predictor and checks every strobed
// output word field by field against the predicted network outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import srn_pkg::*;

  localparam int WatchdogLimit = 200000;

  typedef struct {
    logic [4:0]  idx;
    logic [12:0] val;
    logic        on;
    logic        last;
  } net_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = CFG_INPUTS;
  logic [5:0]        cfg_data_i = '0;
  logic [1:0]        action_i = ACT_NONE;
  logic [5:0]        src_index_i = '0;
  logic [5:0]        dst_index_i = '0;
  logic signed [15:0] weight_i = '0;
  logic [4:0]        input_index_i = '0;
  logic signed [15:0] input_value_i = '0;
  logic              last_input_i = 1'b0;
  logic              out_valid_o;
  logic [4:0]        output_index_o;
  logic [12:0]       output_value_o;
  logic              output_on_o;
  logic              last_o;

  sparse_recurrent_net_step dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state.
  int unsigned     n_inputs = 1, n_outputs = 1, n_hid = 0;
  int              neuron_val[MaxNeurons];
  logic [5:0]      conn_src[MaxConns];
  logic [5:0]      conn_dst[MaxConns];
  int              conn_w[MaxConns];
  int unsigned     conn_cnt = 0;
  net_out_t        pending_outputs[$];

  int unsigned     mismatches = 0;
  int unsigned     words_sent = 0;
  int unsigned     idle_pct = 0;
  int unsigned     quiet_cycles = 0;

  const longint unsigned exp_q16[16] = '{
    65520, 65504, 65472, 65408, 65280, 65026, 64520, 63520,
    61565, 57835, 51039, 39750, 24109, 8869, 1200, 22
  };

  function automatic int sigmoid_q12(longint x);
    longint unsigned a, e, den, p;
    a = (x < 0) ? -x : x;
    e = 65536;
    for (int k = 0; k < 40; k++) begin
      if (a[k]) begin
        if (k < 16) e = (e * exp_q16[k] + 32768) >> 16;
        else e = 0;
      end
    end
    den = 65536 + e;
    p = (longint'(268435456) + den / 2) / den;
    return (x < 0) ? 4096 - int'(p) : int'(p);
  endfunction

  function automatic int unsigned neuron_total();
    int unsigned n;
    n = 1 + n_inputs + n_outputs + n_hid;
    return (n > MaxNeurons) ? MaxNeurons : n;
  endfunction

  function automatic void run_network_step();
    longint      acc[MaxNeurons];
    int          nxt[MaxNeurons];
    int unsigned n, base, outs;
    longint      q;
    net_out_t    o;
    n = neuron_total();
    base = 1 + n_inputs;
    neuron_val[0] = 4096;
    foreach (acc[i]) acc[i] = 0;
    for (int i = 0; i < conn_cnt; i++) begin
      if (conn_src[i] < n && conn_dst[i] < n && conn_dst[i] >= base)
        acc[conn_dst[i]] += longint'(neuron_val[conn_src[i]]) * longint'(conn_w[i]);
    end
    for (int i = base; i < n; i++) begin
      q = acc[i] >>> 12;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      nxt[i] = sigmoid_q12(q);
    end
    for (int i = base; i < n; i++) neuron_val[i] = nxt[i];
    outs = (base >= n) ? 0 : n - base;
    if (outs > n_outputs) outs = n_outputs;
    if (outs > 32) outs = 32;
    for (int i = 0; i < outs; i++) begin
      o.idx = i[4:0];
      o.val = neuron_val[base + i][12:0];
      o.on = neuron_val[base + i] > 2048;
      o.last = (i + 1 == outs);
      pending_outputs.push_back(o);
    end
  endfunction

  function automatic void predict_word(action_e a, logic [5:0] src, logic [5:0] dst,
                                       logic signed [15:0] w, logic [4:0] iidx,
                                       logic signed [15:0] ival, logic lst);
    case (a)
      ACT_CLEAR: begin
        conn_cnt = 0;
        foreach (neuron_val[i]) neuron_val[i] = 4096;
      end
      ACT_ADD: begin
        if (conn_cnt < MaxConns) begin
          conn_src[conn_cnt] = src;
          conn_dst[conn_cnt] = dst;
          conn_w[conn_cnt] = int'(w);
          conn_cnt++;
        end
      end
      ACT_INPUT: begin
        if (iidx < n_inputs && 1 + iidx < neuron_total()) neuron_val[1 + iidx] = int'(ival);
        if (lst) run_network_step();
      end
      default: ;
    endcase
  endfunction

  // Output checker.
  always @(posedge clk_i) begin
    net_out_t e;
    if (rst_ni && out_valid_o) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word idx=%0d val=%0d", output_index_o, output_value_o);
      end else begin
        e = pending_outputs.pop_front();
        if (e.idx !== output_index_o || e.val !== output_value_o ||
            e.on !== output_on_o || e.last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected idx=%0d val=%0d on=%0b last=%0b,",
                     e.idx, e.val, e.on, e.last,
                     " got idx=%0d val=%0d on=%0b last=%0b",
                     output_index_o, output_value_o, output_on_o, last_o);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word or strobed output word.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with start still high.
  task automatic send_word(action_e a, logic [5:0] src = '0, logic [5:0] dst = '0,
                           logic signed [15:0] w = '0, logic [4:0] iidx = '0,
                           logic signed [15:0] ival = '0, logic lst = 1'b0);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    action_i = a;
    src_index_i = src;
    dst_index_i = dst;
    weight_i = w;
    input_index_i = iidx;
    input_value_i = ival;
    last_input_i = lst;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_word(a, src, dst, w, iidx, ival, lst);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_outputs.size() != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [5:0] data);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_INPUTS:  n_inputs = 32'(data[4:0]);
      CFG_OUTPUTS: n_outputs = 32'(data);
      CFG_HIDDEN:  n_hid = 32'(data);
      default: ;
    endcase
  endtask

  task automatic set_shape(int unsigned ni, int unsigned no, int unsigned nh);
    write_cfg(CFG_INPUTS, 6'(ni));
    write_cfg(CFG_OUTPUTS, 6'(no));
    write_cfg(CFG_HIDDEN, 6'(nh));
  endtask

  function automatic logic signed [15:0] rand_weight();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8192) - 4096);
      2: return 16'($urandom_range(0, 1024) - 512);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh1000), .lst(1'b1));
    send_word(ACT_ADD, 6'd0, 6'd2, 16'sh7fff);
    send_word(ACT_ADD, 6'd1, 6'd2, 16'sh7fff);
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh7fff), .lst(1'b1));
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh8000), .lst(1'b1));
  endtask

  task automatic test_directed_cases();
    set_shape(2, 3, 1);
    send_word(ACT_CLEAR);
    send_word(ACT_ADD, 6'd1, 6'd3, 16'sh8000);
    send_word(ACT_ADD, 6'd2, 6'd4, 16'sh1000);
    send_word(ACT_ADD, 6'd6, 6'd5, 16'sh2000);
    send_word(ACT_ADD, 6'd3, 6'd0, 16'sh7fff);
    send_word(ACT_ADD, 6'd3, 6'd1, 16'sh7fff);
    send_word(ACT_ADD, 6'd63, 6'd3, 16'sh7fff);
    send_word(ACT_ADD, 6'd3, 6'd63, 16'sh7fff);
    send_word(ACT_NONE, 6'd1, 6'd3, 16'sh7fff, 5'd0, 16'sh7fff, 1'b1);
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh7fff));
    send_word(ACT_INPUT, .iidx(31), .ival(16'sh1234));
    send_word(ACT_INPUT, .iidx(2), .ival(16'sh0abc));
    send_word(ACT_INPUT, .iidx(1), .ival(16'sh8000), .lst(1'b1));
    send_word(ACT_INPUT, .iidx(5), .ival(16'sh0000), .lst(1'b1));
    set_shape(0, 1, 0);
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh0100), .lst(1'b1));
  endtask

  task automatic test_table_full();
    set_shape(1, 1, 0);
    send_word(ACT_CLEAR);
    for (int i = 0; i < MaxConns + 4; i++)
      send_word(ACT_ADD, 6'($urandom_range(0, 2)), (i < MaxConns) ? 6'd2 : 6'd2,
                (i < MaxConns) ? 16'sh0001 : 16'sh7fff);
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh4000), .lst(1'b1));
    send_word(ACT_INPUT, .iidx(0), .ival(16'sh8000), .lst(1'b1));
  endtask

  task automatic test_extreme_shape();
    set_shape(31, 32, 62);
    send_word(ACT_CLEAR);
    for (int i = 0; i < 12; i++)
      send_word(ACT_ADD, 6'($urandom_range(0, 63)), 6'($urandom_range(32, 63)),
                rand_weight());
    send_word(ACT_INPUT, .iidx(30), .ival(16'sh7fff));
    send_word(ACT_INPUT, .iidx(0), .ival(16'($urandom)), .lst(1'b1));
    send_word(ACT_INPUT, .iidx(17), .ival(16'($urandom)), .lst(1'b1));
  endtask

  task automatic test_random_networks(int unsigned target);
    int unsigned n, nadd, nin;
    while (words_sent < target) begin
      if ($urandom_range(9) == 0)
        set_shape($urandom_range(0, 31), $urandom_range(1, 32), $urandom_range(0, 62));
      else
        set_shape($urandom_range(0, 4), $urandom_range(1, 4), $urandom_range(0, 4));
      n = neuron_total();
      send_word(ACT_CLEAR);
      nadd = $urandom_range(0, 14);
      for (int i = 0; i < nadd; i++) begin
        if ($urandom_range(9) == 0)
          send_word(ACT_ADD, 6'($urandom), 6'($urandom), 16'($urandom));
        else
          send_word(ACT_ADD, 6'($urandom_range(0, n - 1)),
                    6'($urandom_range(1 + n_inputs < n ? 1 + n_inputs : 0, n - 1)),
                    rand_weight());
      end
      repeat ($urandom_range(1, 3)) begin
        nin = $urandom_range(0, 3);
        for (int i = 0; i <= nin; i++) begin
          if ($urandom_range(19) == 0)
            send_word(ACT_NONE, 6'($urandom), 6'($urandom), 16'($urandom),
                      5'($urandom), 16'($urandom), 1'($urandom));
          else
            send_word(ACT_INPUT, .iidx($urandom_range(19) == 0 ? 5'($urandom) :
                                       5'($urandom_range(0, n_inputs))),
                      .ival($urandom_range(1) ? 16'($urandom) :
                            16'($urandom_range(0, 8192) - 4096)),
                      .lst(i == nin));
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (neuron_val[i]) neuron_val[i] = 4096;
    @(negedge clk_i);
    idle_pct = 22;
    test_reset_defaults();
    test_directed_cases();
    test_table_full();
    test_extreme_shape();
    test_random_networks(words_sent + 110);
    idle_pct = 61;
    test_random_networks(words_sent + 60);
    idle_pct = 0;
    test_random_networks(words_sent + 20);
    wait_drained();
    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
